// ===== design/qwt_pkg.sv =====
// Shared types and constants of the quoted word tokenizer.
package qwt_pkg;

	localparam logic [7:0] QUOTE_SINGLE = 8'h27;
	localparam logic [7:0] QUOTE_DOUBLE = 8'h22;
	localparam logic [7:0] BACKSLASH    = 8'h5C;

	localparam int unsigned REG_INDEX_W = 3;
	localparam int unsigned SEP_NUM     = 4;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_SEP_A     = 3'd0,
		REG_SEP_B     = 3'd1,
		REG_SEP_C     = 3'd2,
		REG_SEP_D     = 3'd3,
		REG_SEP_COUNT = 3'd4
	} reg_index_t;

	localparam logic [7:0] SEP_A_RST     = 8'd32;
	localparam logic [7:0] SEP_B_RST     = 8'd9;
	localparam logic [7:0] SEP_C_RST     = 8'd10;
	localparam logic [7:0] SEP_D_RST     = 8'd0;
	localparam logic [2:0] SEP_COUNT_RST = 3'd3;

	typedef enum logic {
		KIND_CHAR = 1'b0,
		KIND_END  = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] word_byte;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ===== design/qwt_ifs.sv =====
// Channel interfaces: input bytes, result beats and register writes.
interface qwt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_line;

	modport source (output valid, in_byte, end_of_line, input ready);
	modport sink (input valid, in_byte, end_of_line, output ready);
endinterface

interface qwt_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] word_byte;
	logic       last_of_run;

	modport source (output valid, result_kind, word_byte, last_of_run, input ready);
	modport sink (input valid, result_kind, word_byte, last_of_run, output ready);
endinterface

interface qwt_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] reg_index;
	logic [7:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== design/qwt_result_buf.sv =====
// Two-entry result queue that takes up to two results per cycle, as room allows, and sends one while ready.
module qwt_result_buf
	import qwt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic [1:0]  room,
	qwt_out_if.source   out_ch
);

	logic [1:0] cnt_q;
	result_t    ent_q [2];
	logic       pop;
	logic [1:0] base;
	logic [1:0] cnt_d;
	result_t    e0_d;
	result_t    e1_d;

	assign pop  = (cnt_q != 2'd0) && out_ch.ready;
	assign room = 2'd2 - cnt_q + {1'b0, pop};

	always_comb begin
		base  = pop ? cnt_q - 2'd1 : cnt_q;
		e0_d  = pop ? ent_q[1] : ent_q[0];
		e1_d  = ent_q[1];
		if (push.cnt != 2'd0) begin
			if (base == 2'd0) begin
				e0_d = push.r0;
			end else begin
				e1_d = push.r0;
			end
		end
		if (push.cnt == 2'd2) begin
			e1_d = push.r1;
		end
		cnt_d = base + push.cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= e0_d;
		ent_q[1] <= e1_d;
	end

	assign out_ch.valid       = cnt_q != 2'd0;
	assign out_ch.result_kind = ent_q[0].result_kind;
	assign out_ch.word_byte   = ent_q[0].word_byte;
	assign out_ch.last_of_run = ent_q[0].last_of_run;

endmodule

// ===== design/quoted_word_tokenizer.sv =====
// Top level: splits a byte stream into words with quotes and backslash escapes.
// An accepted byte is registered in the input stage; its results enter the result queue once it has room.
// Throughput: one byte per cycle while each byte gives at most one result and the output is not stalled;
// a byte that gives two results sends them in turn over the single result port.
// Reset: arst_n clears the tokenizer state, the input stage and the result queue, and loads the separator defaults.
module quoted_word_tokenizer
	import qwt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	qwt_in_if.sink    in_ch,
	qwt_out_if.source out_ch,
	qwt_cfg_if.sink   cfg_ch
);

	logic [7:0] sep_a_q, sep_b_q, sep_c_q, sep_d_q;
	logic [2:0] sep_count_q;

	logic       in_quote_q, quote_single_q, escape_q, word_chars_q;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eol_s1;

	logic       is_quote, is_sq, is_sep;
	logic       emit_char, emit_mark, eol_mark;
	logic       in_quote_d, quote_single_d, escape_d, word_chars_d;
	logic [1:0] need;
	logic [1:0] room;
	logic       fire;
	push_t      push;
	result_t    char_res, mark_res;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_a_q     <= SEP_A_RST;
			sep_b_q     <= SEP_B_RST;
			sep_c_q     <= SEP_C_RST;
			sep_d_q     <= SEP_D_RST;
			sep_count_q <= SEP_COUNT_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.reg_index)
				REG_SEP_A:     sep_a_q     <= cfg_ch.wdata;
				REG_SEP_B:     sep_b_q     <= cfg_ch.wdata;
				REG_SEP_C:     sep_c_q     <= cfg_ch.wdata;
				REG_SEP_D:     sep_d_q     <= cfg_ch.wdata;
				REG_SEP_COUNT: sep_count_q <= cfg_ch.wdata[2:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			eol_s1  <= in_ch.end_of_line;
		end
	end

	always_comb begin
		is_sq    = byte_s1 == QUOTE_SINGLE;
		is_quote = is_sq || (byte_s1 == QUOTE_DOUBLE);
		is_sep   = ((sep_count_q >= 3'd1) && (byte_s1 == sep_a_q))
			|| ((sep_count_q >= 3'd2) && (byte_s1 == sep_b_q))
			|| ((sep_count_q >= 3'd3) && (byte_s1 == sep_c_q))
			|| ((sep_count_q >= 3'd4) && (byte_s1 == sep_d_q));

		emit_char      = 1'b0;
		emit_mark      = 1'b0;
		in_quote_d     = in_quote_q;
		quote_single_d = quote_single_q;
		escape_d       = escape_q;
		word_chars_d   = word_chars_q;

		priority if (escape_q) begin
			escape_d     = 1'b0;
			emit_char    = 1'b1;
			word_chars_d = 1'b1;
		end else if (is_quote && !in_quote_q) begin
			in_quote_d     = 1'b1;
			quote_single_d = is_sq;
		end else if (is_quote && (quote_single_q == is_sq)) begin
			in_quote_d = 1'b0;
		end else if (!in_quote_q && is_sep) begin
			emit_mark    = word_chars_q;
			word_chars_d = 1'b0;
		end else if ((byte_s1 == BACKSLASH) && !(in_quote_q && quote_single_q)) begin
			escape_d = 1'b1;
		end else begin
			emit_char    = 1'b1;
			word_chars_d = 1'b1;
		end

		eol_mark = eol_s1 && word_chars_d;
		if (eol_s1) begin
			in_quote_d     = 1'b0;
			quote_single_d = 1'b0;
			escape_d       = 1'b0;
			word_chars_d   = 1'b0;
		end

		need = {1'b0, emit_char || emit_mark} + {1'b0, eol_mark};

		char_res.result_kind = KIND_CHAR;
		char_res.word_byte   = byte_s1;
		char_res.last_of_run = need == 2'd1;
		mark_res.result_kind = KIND_END;
		mark_res.word_byte   = 8'd0;
		mark_res.last_of_run = 1'b1;

		fire     = v_s1 && (need <= room);
		push.cnt = fire ? need : 2'd0;
		push.r0  = emit_char ? char_res : mark_res;
		push.r1  = mark_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q     <= 1'b0;
			quote_single_q <= 1'b0;
			escape_q       <= 1'b0;
			word_chars_q   <= 1'b0;
		end else if (fire) begin
			in_quote_q     <= in_quote_d;
			quote_single_q <= quote_single_d;
			escape_q       <= escape_d;
			word_chars_q   <= word_chars_d;
		end
	end

	qwt_result_buf u_result_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_ch (out_ch)
	);

endmodule

// ===== design/qwt_checker.sv =====
// Port-level assertions for the quoted word tokenizer, bound to the top level.
module qwt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       result_kind,
	input logic [7:0] word_byte,
	input logic       last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind)
			&& $stable(word_byte) && $stable(last_of_run))
		else $error("result beat changed while stalled");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind |-> word_byte == 8'd0)
		else $error("end marker carries a nonzero byte");

	a_pair_first_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !result_kind)
		else $error("first beat of a pair is not a character");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && result_kind)
		else $error("second beat of a pair missing");

endmodule

bind quoted_word_tokenizer qwt_checker u_qwt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.result_kind (out_ch.result_kind),
	.word_byte   (out_ch.word_byte),
	.last_of_run (out_ch.last_of_run)
);

// ===== tb/sv/quoted_word_tokenizer_tb.sv =====
// Testbench of the quoted word tokenizer: directed and random command lines, scoreboard check.
module quoted_word_tokenizer_tb
	import qwt_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] SPACE = 8'h20;
	localparam int DRAIN_CYCLES = 8;

	class word_scoreboard;
		logic [7:0] sep [SEP_NUM];
		logic [2:0] sep_count;
		bit in_quote;
		bit quote_single;
		bit escape_pending;
		bit word_open;
		result_t expected_q[$];
		int errors;
		int n_checked;
		int n_word_ends;

		function new();
			sep[0] = SEP_A_RST;
			sep[1] = SEP_B_RST;
			sep[2] = SEP_C_RST;
			sep[3] = SEP_D_RST;
			sep_count = SEP_COUNT_RST;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] data);
			case (idx)
				REG_SEP_A: sep[0] = data;
				REG_SEP_B: sep[1] = data;
				REG_SEP_C: sep[2] = data;
				REG_SEP_D: sep[3] = data;
				REG_SEP_COUNT: sep_count = data[2:0];
				default: ;
			endcase
		endfunction

		function bit is_sep(logic [7:0] b);
			int n;
			n = (sep_count > SEP_NUM) ? SEP_NUM : sep_count;
			for (int i = 0; i < n; i++)
				if (b == sep[i]) return 1'b1;
			return 1'b0;
		endfunction

		// Work out the beats that one accepted byte causes.
		function void note_byte(logic [7:0] b, logic eol);
			result_t r [2];
			int n;
			bit is_quote;
			n = 0;
			is_quote = (b == QUOTE_SINGLE) || (b == QUOTE_DOUBLE);
			if (escape_pending) begin
				escape_pending = 1'b0;
				r[n] = '{KIND_CHAR, b, 1'b0};
				n++;
				word_open = 1'b1;
			end else if (is_quote && !in_quote) begin
				in_quote = 1'b1;
				quote_single = (b == QUOTE_SINGLE);
			end else if (is_quote && quote_single == (b == QUOTE_SINGLE)) begin
				in_quote = 1'b0;
			end else if (!in_quote && is_sep(b)) begin
				if (word_open) begin
					r[n] = '{KIND_END, 8'h00, 1'b0};
					n++;
					word_open = 1'b0;
				end
			end else if (b == BACKSLASH && !(in_quote && quote_single)) begin
				escape_pending = 1'b1;
			end else begin
				r[n] = '{KIND_CHAR, b, 1'b0};
				n++;
				word_open = 1'b1;
			end
			if (eol) begin
				if (word_open) begin
					r[n] = '{KIND_END, 8'h00, 1'b0};
					n++;
				end
				in_quote = 1'b0;
				quote_single = 1'b0;
				escape_pending = 1'b0;
				word_open = 1'b0;
			end
			if (n > 0) r[n-1].last_of_run = 1'b1;
			for (int i = 0; i < n; i++) expected_q.push_back(r[i]);
		endfunction

		function void check_beat(logic kind, logic [7:0] b, logic last);
			result_t r;
			if (expected_q.size() == 0) begin
				$error("unexpected beat: result_kind %0d word_byte %02h last_of_run %0d",
					kind, b, last);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			n_checked++;
			if (r.result_kind == KIND_END) n_word_ends++;
			if (kind !== r.result_kind) begin
				$error("result_kind: expected %0d, actual %0d", r.result_kind, kind);
				errors++;
			end
			if (b !== r.word_byte) begin
				$error("word_byte: expected %02h, actual %02h", r.word_byte, b);
				errors++;
			end
			if (last !== r.last_of_run) begin
				$error("last_of_run: expected %0d, actual %0d", r.last_of_run, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	qwt_in_if  in_ch();
	qwt_out_if out_ch();
	qwt_cfg_if cfg_ch();

	quoted_word_tokenizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	word_scoreboard sb = new();
	bit idle_on;
	bit stall_on;
	int bytes_sent;
	int n_writes;
	int n_settings;
	logic [7:0] line_q[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("quoted_word_tokenizer_tb: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_beat(out_ch.result_kind, out_ch.word_byte, out_ch.last_of_run);
	end

	initial begin
		int r;
		int n;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 99);
			if (!stall_on || r < 70) begin
				out_ch.ready <= 1'b1;
			end else begin
				n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				out_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic eol);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.end_of_line <= eol;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_byte(b, eol);
		bytes_sent++;
	endtask

	task automatic in_gap();
		int r;
		int n;
		if (!idle_on) return;
		r = $urandom_range(0, 99);
		if (r < 60) n = 0;
		else if (r < 93) n = $urandom_range(1, 3);
		else n = $urandom_range(8, 40);
		if (n > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic in_release();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Hold until every expected beat is in, then let in-flight bytes settle.
	task automatic wait_drained();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		sb.write_reg(idx, data);
		n_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_separators(logic [7:0] a, logic [7:0] b, logic [7:0] c,
			logic [7:0] d, logic [7:0] count);
		write_reg(REG_SEP_A, a);
		write_reg(REG_SEP_B, b);
		write_reg(REG_SEP_C, c);
		write_reg(REG_SEP_D, d);
		write_reg(REG_SEP_COUNT, count);
	endtask

	function automatic logic [7:0] pick_sep();
		int n;
		n = (sb.sep_count > SEP_NUM) ? SEP_NUM : sb.sep_count;
		if (n == 0) return SPACE;
		return sb.sep[$urandom_range(0, n - 1)];
	endfunction

	function automatic logic [7:0] pick_text();
		if ($urandom_range(0, 99) < 70) return 8'h61 + 8'($urandom_range(0, 25));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_inner(logic [7:0] other_quote);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return pick_text();
		if (r < 70) return pick_sep();
		if (r < 80) return other_quote;
		if (r < 90) return BACKSLASH;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_noise();
		case ($urandom_range(0, 5))
			0: return QUOTE_SINGLE;
			1: return QUOTE_DOUBLE;
			2: return BACKSLASH;
			3: return pick_sep();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_quoted(logic [7:0] q, int len);
		logic [7:0] other;
		other = (q == QUOTE_SINGLE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
		line_q.push_back(q);
		for (int i = 0; i < len; i++) line_q.push_back(pick_inner(other));
		line_q.push_back(q);
	endfunction

	function automatic void add_token();
		int len;
		logic [7:0] q;
		q = $urandom_range(0, 1) ? QUOTE_SINGLE : QUOTE_DOUBLE;
		case ($urandom_range(0, 5))
			0: begin
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++) line_q.push_back(pick_text());
			end
			1: add_quoted(QUOTE_SINGLE, $urandom_range(0, 4));
			2: add_quoted(QUOTE_DOUBLE, $urandom_range(0, 4));
			3: begin
				line_q.push_back(BACKSLASH);
				line_q.push_back(8'($urandom_range(0, 255)));
			end
			4: begin
				line_q.push_back(q);
				line_q.push_back(q);
			end
			default: begin
				line_q.push_back(pick_text());
				add_quoted(q, $urandom_range(1, 3));
				line_q.push_back(pick_text());
			end
		endcase
	endfunction

	// Mostly well-formed lines of words, quotes and escapes; the rest is noise.
	function automatic void build_line();
		int n;
		int r;
		line_q.delete();
		if ($urandom_range(0, 99) < 15) begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++) line_q.push_back(pick_noise());
			return;
		end
		if ($urandom_range(0, 3) == 0) line_q.push_back(pick_sep());
		n = $urandom_range(1, 4);
		for (int t = 0; t < n; t++) begin
			add_token();
			if (t < n - 1)
				repeat ($urandom_range(1, 3)) line_q.push_back(pick_sep());
		end
		r = $urandom_range(0, 99);
		if (r < 10) line_q.push_back(BACKSLASH);
		else if (r < 18) line_q.push_back($urandom_range(0, 1) ? QUOTE_SINGLE : QUOTE_DOUBLE);
		else if (r < 30) line_q.push_back(pick_sep());
	endfunction

	task automatic send_line();
		foreach (line_q[i]) begin
			send_byte(line_q[i], i == line_q.size() - 1);
			in_gap();
		end
	endtask

	task automatic run_phase(int n_bytes, bit with_idle);
		int start;
		idle_on = with_idle;
		stall_on = with_idle;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			build_line();
			send_line();
		end
		in_release();
		wait_drained();
		n_settings++;
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.end_of_line = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = REG_SEP_A;
		cfg_ch.wdata = 8'h00;
		idle_on = 1'b1;
		stall_on = 1'b1;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		send_byte("a", 1'b0);
		send_byte(SPACE, 1'b0);
		send_byte(SPACE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(QUOTE_DOUBLE, 1'b0);
		send_byte(SPACE, 1'b0);
		send_byte(QUOTE_SINGLE, 1'b0);
		send_byte(QUOTE_DOUBLE, 1'b0);
		send_byte(QUOTE_SINGLE, 1'b0);
		send_byte(BACKSLASH, 1'b0);
		send_byte(QUOTE_DOUBLE, 1'b0);
		send_byte(QUOTE_SINGLE, 1'b0);
		send_byte(BACKSLASH, 1'b0);
		send_byte(QUOTE_DOUBLE, 1'b0);
		send_byte(SPACE, 1'b0);
		send_byte(QUOTE_DOUBLE, 1'b0);
		send_byte(QUOTE_DOUBLE, 1'b0);
		send_byte(SPACE, 1'b0);
		send_byte(BACKSLASH, 1'b1);
		send_byte(QUOTE_SINGLE, 1'b0);
		send_byte("z", 1'b1);
		send_byte("q", 1'b1);
		send_byte(BACKSLASH, 1'b0);
		send_byte("x", 1'b1);
		in_release();
		wait_drained();

		run_phase(260, 1'b1);

		set_separators(",", ";", 8'h00, 8'hFF, 8'd4);
		run_phase(260, 1'b1);

		write_reg(REG_SEP_COUNT, 8'd0);
		run_phase(240, 1'b0);

		set_separators(QUOTE_SINGLE, BACKSLASH, SPACE, QUOTE_DOUBLE, 8'hFD);
		run_phase(260, 1'b1);

		set_separators(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd7);
		for (int i = REG_SEP_COUNT + 1; i < (1 << REG_INDEX_W); i++)
			write_reg(3'(i), 8'($urandom_range(0, 255)));
		run_phase(260, 1'b1);

		set_separators(8'hFF, SPACE, 8'h00, 8'h00, 8'd1);
		run_phase(140, 1'b1);
		write_reg(REG_SEP_COUNT, 8'd2);
		run_phase(140, 1'b0);

		set_separators(SEP_A_RST, SEP_B_RST, SEP_C_RST, SEP_D_RST, 8'(SEP_COUNT_RST));
		run_phase(260, 1'b1);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d bytes over %0d separator settings (%0d register writes)",
			bytes_sent, n_settings, n_writes);
		$display("checked %0d result beats, %0d of them word ends, %0d errors",
			sb.n_checked, sb.n_word_ends, sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("quoted_word_tokenizer_tb: PASS");
		else
			$display("quoted_word_tokenizer_tb: FAIL");
		$finish;
	end

endmodule
